// ----- hdl/pbu_pkg.sv -----
package pbu_pkg;

	localparam int PAL_AW       = 8;
	localparam int BLOCK_ID_W   = 8;
	localparam int CELL_W       = 13;
	localparam int STREAM_W     = 71;
	localparam int CARRY_W      = 7;
	localparam int AVAIL_W      = 7;
	localparam int MAX_PER_WORD = 16;
	localparam logic [CELL_W-1:0] SECTION_CELLS = 13'd4096;

	localparam logic [2:0] REG_PALETTE_SIZE = 3'd0;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} unpack_state_t;

	// One cell on its way from the extractor to the palette lookup.
	typedef struct packed {
		logic [PAL_AW-1:0] idx;
		logic [11:0]       cell_num;
		logic              valid;
		logic              complete;
		logic              short_data;
		logic              last;
	} cell_t;

	// Index width is the smallest width of at least 4 bits that covers the palette, capped at 8 bits.
	function automatic logic [3:0] index_width(input logic [8:0] psize);
		logic [3:0] w;
		begin
			if (psize <= 9'd16) begin
				w = 4'd4;
			end else if (psize <= 9'd32) begin
				w = 4'd5;
			end else if (psize <= 9'd64) begin
				w = 4'd6;
			end else if (psize <= 9'd128) begin
				w = 4'd7;
			end else begin
				w = 4'd8;
			end
			return w;
		end
	endfunction

endpackage

// ----- hdl/pbu_palette_ram.sv -----
module pbu_palette_ram
	import pbu_pkg::*;
(
	input  logic                  clk,
	input  logic                  we,
	input  logic [PAL_AW-1:0]     waddr,
	input  logic [BLOCK_ID_W-1:0] wdata,
	input  logic                  re,
	input  logic [PAL_AW-1:0]     raddr,
	output logic [BLOCK_ID_W-1:0] rdata
);

	logic [BLOCK_ID_W-1:0] mem [2**PAL_AW];
	logic [BLOCK_ID_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/pbu_unpack.sv -----
module pbu_unpack
	import pbu_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic [8:0]   palette_size,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         operation,
	input  logic [63:0]  packed_word,
	input  logic         last_word,
	input  logic         issue_ok,
	output logic         issue,
	output cell_t        cur_cell
);

	unpack_state_t state_q, state_d;

	logic [STREAM_W-1:0] buf_q;
	logic [AVAIL_W-1:0]  avail_q;
	logic [3:0]          w_q;
	logic                last_q;
	logic [3:0]          n_q;
	logic [CELL_W-1:0]   counter_q;
	logic [CARRY_W-1:0]  carry_q;
	logic [2:0]          ccount_q;

	logic                data_acc;
	logic [STREAM_W-1:0] buf_shift;
	logic [AVAIL_W-1:0]  avail_next;
	logic [PAL_AW-1:0]   idx;
	logic                cell_last;
	logic [CELL_W-1:0]   counter_inc;

	assign data_acc = in_valid && in_ready && operation;

	always_comb begin
		case (w_q)
			4'd4:    buf_shift = buf_q >> 4;
			4'd5:    buf_shift = buf_q >> 5;
			4'd6:    buf_shift = buf_q >> 6;
			4'd7:    buf_shift = buf_q >> 7;
			default: buf_shift = buf_q >> 8;
		endcase
	end

	assign idx         = buf_q[PAL_AW-1:0] & (8'hFF >> (4'd8 - w_q));
	assign avail_next  = avail_q - {3'b0, w_q};
	assign counter_inc = counter_q + 13'd1;
	assign cell_last   = (n_q == 4'(MAX_PER_WORD - 1)) || (counter_inc == SECTION_CELLS) ||
		(avail_next < {3'b0, w_q});

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		issue    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (data_acc && !counter_q[CELL_W-1]) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				issue = issue_ok;
				if (issue_ok && cell_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cur_cell.idx        = idx;
		cur_cell.cell_num   = counter_q[11:0];
		cur_cell.valid      = {1'b0, idx} < palette_size;
		cur_cell.complete   = counter_inc == SECTION_CELLS;
		cur_cell.short_data = last_q && cell_last && (counter_inc != SECTION_CELLS);
		cur_cell.last       = cell_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			counter_q <= '0;
			carry_q   <= '0;
			ccount_q  <= '0;
			n_q       <= '0;
			last_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (data_acc) begin
				if (counter_q[CELL_W-1]) begin
					// The section is already full: the word is dropped.
					carry_q  <= '0;
					ccount_q <= '0;
					if (last_word) begin
						counter_q <= '0;
					end
				end else begin
					n_q    <= '0;
					last_q <= last_word;
				end
			end
			if (issue) begin
				counter_q <= counter_inc;
				n_q       <= n_q + 4'd1;
				if (cell_last) begin
					if (last_q) begin
						counter_q <= '0;
						carry_q   <= '0;
						ccount_q  <= '0;
					end else if (counter_inc == SECTION_CELLS) begin
						carry_q  <= '0;
						ccount_q <= '0;
					end else begin
						// Bits above the stream's end are zero, so the low bits are the carry.
						carry_q  <= buf_shift[CARRY_W-1:0];
						ccount_q <= (avail_next > 7'd7) ? 3'd7 : avail_next[2:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (data_acc) begin
			buf_q   <= ({7'b0, packed_word} << ccount_q) | {64'b0, carry_q};
			avail_q <= 7'd64 + {4'b0, ccount_q};
			w_q     <= index_width(palette_size);
		end else if (issue) begin
			buf_q   <= buf_shift;
			avail_q <= avail_next;
		end
	end

endmodule

// ----- hdl/palette_bitstream_unpacker.sv -----
// Palette bitstream unpacker. An item with operation 0 writes one palette entry
// and gives no result. An item with operation 1 carries a 64-bit word of packed
// indices; the unpacker cuts it into cells of max(4, ceil(log2(palette_size)))
// bits (8 at most), LSB first, with up to seven leftover bits carried into the
// next word, and gives one result per cell, at most 16 per word. Cells leave one
// per clock while the output does not stall, and a data word keeps in_ready low
// until its last cell has been issued. Each cell reads the palette memory
// through its single read port; the read data and then the result are registered
// before the result appears. Words that arrive after the 4096th cell of a
// section give no result; last_word closes the section.
module palette_bitstream_unpacker
	import pbu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  palette_slot,
	input  logic [7:0]  palette_block_id,
	input  logic [63:0] packed_word,
	input  logic        last_word,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  block_x,
	output logic [3:0]  block_y,
	output logic [3:0]  block_z,
	output logic [7:0]  block_id,
	output logic [7:0]  palette_index,
	output logic        index_valid,
	output logic        section_complete,
	output logic        short_data,
	output logic        last_of_run
);

	logic [8:0]            palette_size_q;
	logic                  cfg_write;
	logic                  pal_we;
	logic                  issue;
	logic                  issue_ok;
	cell_t                 cur_cell;
	cell_t                 cell_s1;
	logic                  valid_s1;
	logic                  adv_s1;
	logic [BLOCK_ID_W-1:0] rd_data;
	cell_t                 out_q;
	logic [BLOCK_ID_W-1:0] id_q;
	logic                  out_valid_q;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_PALETTE_SIZE[0]) ? {23'b0, palette_size_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= 9'd2;
		end else if (cfg_write && (paddr[2] == REG_PALETTE_SIZE[0])) begin
			palette_size_q <= pwdata[8:0];
		end
	end

	assign pal_we = in_valid && in_ready && !operation;

	pbu_unpack u_unpack (
		.clk          (clk),
		.arst_n       (arst_n),
		.palette_size (palette_size_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.packed_word  (packed_word),
		.last_word    (last_word),
		.issue_ok     (issue_ok),
		.issue        (issue),
		.cur_cell     (cur_cell)
	);

	pbu_palette_ram u_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (palette_slot),
		.wdata (palette_block_id),
		.re    (issue),
		.raddr (cur_cell.idx),
		.rdata (rd_data)
	);

	// The read data stays put while stage one stalls, since no new read is issued.
	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign issue_ok = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cell_s1 <= cur_cell;
		end
		if (adv_s1) begin
			out_q <= cell_s1;
			id_q  <= cell_s1.valid ? rd_data : '0;
		end
	end

	assign out_valid        = out_valid_q;
	assign block_x          = out_q.cell_num[3:0];
	assign block_z          = out_q.cell_num[7:4];
	assign block_y          = out_q.cell_num[11:8];
	assign block_id         = id_q;
	assign palette_index    = out_q.idx;
	assign index_valid      = out_q.valid;
	assign section_complete = out_q.complete;
	assign short_data       = out_q.short_data;
	assign last_of_run      = out_q.last;

endmodule

// ----- dv/tb_palette_bitstream_unpacker.sv -----
`timescale 1ns / 1ps

module tb_palette_bitstream_unpacker;
	import pbu_pkg::*;

	localparam int CELLS_PER_SECTION = int'(SECTION_CELLS);
	localparam logic [2:0] ADDR_PALETTE_SIZE = 3'(REG_PALETTE_SIZE * 4);
	localparam logic OP_PALETTE_WRITE = 1'b0;
	localparam logic OP_DATA_WORD = 1'b1;
	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 8;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_MOSTLY
	} rx_mode_t;

	// Field order matches the concatenation of the result ports.
	typedef struct packed {
		logic [3:0] x;
		logic [3:0] y;
		logic [3:0] z;
		logic [7:0] id;
		logic [7:0] idx;
		logic       valid;
		logic       complete;
		logic       short_d;
		logic       last;
	} cell_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        operation = 1'b0;
	logic [7:0]  palette_slot = '0;
	logic [7:0]  palette_block_id = '0;
	logic [63:0] packed_word = '0;
	logic        last_word = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  block_x;
	logic [3:0]  block_y;
	logic [3:0]  block_z;
	logic [7:0]  block_id;
	logic [7:0]  palette_index;
	logic        index_valid;
	logic        section_complete;
	logic        short_data;
	logic        last_of_run;

	// Shadow state of the unpacker.
	logic [7:0] pal_mem [256];
	bit         pal_written [256];
	logic [8:0] pal_size = 9'd2;
	logic [6:0] carry_q = '0;
	int         carry_n = 0;
	int         cells_done = 0;

	cell_res_t pending_cells[$];
	int        mismatches = 0;
	int        items_sent = 0;
	int        burst_left = 0;
	int        idle_cycles = 0;
	bit        hold_req = 1'b0;

	palette_bitstream_unpacker u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.palette_slot(palette_slot),
		.palette_block_id(palette_block_id),
		.packed_word(packed_word),
		.last_word(last_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.block_x(block_x),
		.block_y(block_y),
		.block_z(block_z),
		.block_id(block_id),
		.palette_index(palette_index),
		.index_valid(index_valid),
		.section_complete(section_complete),
		.short_data(short_data),
		.last_of_run(last_of_run)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int idx_width(logic [8:0] ps);
		int eff;
		int w;
		eff = (ps > 9'd256) ? 256 : int'(ps);
		w = 4;
		while ((1 << w) < eff)
			w++;
		return w;
	endfunction

	// An index may be sent when it is invalid or its palette entry holds a value.
	function automatic bit idx_legal(int c);
		if (c < int'(pal_size))
			return pal_written[c];
		return 1'b1;
	endfunction

	// Picks a legal index of w bits whose low f bits equal fv.
	function automatic int pick_index(int w, int f, int fv);
		int fmask;
		int wmask;
		int cand;
		int start;
		fmask = (1 << f) - 1;
		wmask = (1 << w) - 1;
		repeat (8) begin
			cand = ((int'($urandom) << f) | fv) & wmask;
			if (idx_legal(cand))
				return cand;
		end
		start = $urandom_range(0, wmask);
		for (int j = 0; j <= wmask; j++) begin
			cand = (start + j) & wmask;
			if ((cand & fmask) == fv && idx_legal(cand))
				return cand;
		end
		return fv;
	endfunction

	// Builds a random data word whose cells never read an unwritten entry. The
	// leftover bits at the top start a legal index, so the next word can finish it.
	function automatic logic [63:0] make_packed_word();
		logic [70:0] strm;
		int w;
		int total;
		int ncell;
		int pos;
		int f;
		int fv;
		int idx;
		int t;
		strm = 71'({$urandom, $urandom, $urandom});
		if (cells_done >= CELLS_PER_SECTION)
			return strm[63:0];
		for (int b = 0; b < carry_n; b++)
			strm[b] = carry_q[b];
		w = idx_width(pal_size);
		total = carry_n + 64;
		ncell = total / w;
		if (ncell > MAX_PER_WORD)
			ncell = MAX_PER_WORD;
		if (ncell > CELLS_PER_SECTION - cells_done)
			ncell = CELLS_PER_SECTION - cells_done;
		pos = 0;
		for (int k = 0; k < ncell; k++) begin
			f = carry_n - pos;
			if (f < 0)
				f = 0;
			if (f > w)
				f = w;
			fv = 0;
			for (int b = 0; b < f; b++)
				fv |= int'(strm[pos + b]) << b;
			idx = pick_index(w, f, fv);
			for (int b = f; b < w; b++)
				strm[pos + b] = idx[b];
			pos += w;
		end
		if (cells_done + ncell < CELLS_PER_SECTION) begin
			t = pick_index(w, 0, 0);
			for (int b = 0; b < w; b++) begin
				if (pos + b < total && pos + b >= carry_n)
					strm[pos + b] = t[b];
			end
		end
		strm = strm >> carry_n;
		return strm[63:0];
	endfunction

	// Cuts one accepted data word into cells and queues the results it must give.
	function automatic void unpack_word(logic [63:0] word, logic last);
		logic [70:0] strm;
		int w;
		int total;
		int pos;
		int idx;
		int rem;
		cell_res_t r;
		cell_res_t run[$];
		strm = (71'(word) << carry_n) | 71'(carry_q);
		w = idx_width(pal_size);
		total = carry_n + 64;
		pos = 0;
		if (cells_done < CELLS_PER_SECTION) begin
			while (run.size() < MAX_PER_WORD && cells_done < CELLS_PER_SECTION
					&& total - pos >= w) begin
				idx = int'((strm >> pos) & ((71'd1 << w) - 71'd1));
				r = '0;
				r.x = cells_done[3:0];
				r.z = cells_done[7:4];
				r.y = cells_done[11:8];
				r.idx = idx[7:0];
				r.valid = (idx < int'(pal_size));
				r.id = r.valid ? pal_mem[idx] : 8'd0;
				r.complete = (cells_done + 1 == CELLS_PER_SECTION);
				run = {run, r};
				cells_done++;
				pos += w;
			end
			if (cells_done < CELLS_PER_SECTION) begin
				rem = total - pos;
				if (rem > 7)
					rem = 7;
				carry_q = 7'((strm >> pos) & ((71'd1 << rem) - 71'd1));
				carry_n = rem;
			end else begin
				carry_q = '0;
				carry_n = 0;
			end
		end else begin
			carry_q = '0;
			carry_n = 0;
		end
		if (last) begin
			if (cells_done < CELLS_PER_SECTION) begin
				if (run.size() > 0) begin
					r = run.pop_back();
					r.short_d = 1'b1;
					run = {run, r};
				end else begin
					r = '0;
					r.short_d = 1'b1;
					run = {run, r};
				end
			end
			cells_done = 0;
			carry_q = '0;
			carry_n = 0;
		end
		if (run.size() > 0) begin
			r = run.pop_back();
			r.last = 1'b1;
			run = {run, r};
		end
		pending_cells = {pending_cells, run};
	endfunction

	function automatic string cell_text(cell_res_t c);
		return $sformatf("x=%0d y=%0d z=%0d id=%0d idx=%0d valid=%0b complete=%0b %s",
			c.x, c.y, c.z, c.id, c.idx, c.valid, c.complete,
			$sformatf("short=%0b last=%0b", c.short_d, c.last));
	endfunction

	task automatic note_mismatch(string what, cell_res_t want, cell_res_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s", $realtime, what);
			$display("  expected %s", cell_text(want));
			$display("  actual   %s", cell_text(got));
		end
	endtask

	always @(posedge clk) begin : result_check
		cell_res_t got;
		cell_res_t want;
		if (out_valid === 1'b1 && out_ready) begin
			got = {block_x, block_y, block_z, block_id, palette_index, index_valid,
				section_complete, short_data, last_of_run};
			if (pending_cells.size() == 0) begin
				note_mismatch("result with none expected", '0, got);
			end else begin
				want = pending_cells.pop_front();
				if (got !== want)
					note_mismatch("result mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver: changes its stall pattern now and then; a requested hold keeps
	// out_ready low long enough for the unpacker to back up into its input.
	initial begin : rx_stall
		rx_mode_t mode;
		int mode_left;
		int hold_left;
		mode = RX_OPEN;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 160);
				end
				mode_left--;
				case (mode)
				RX_OPEN:   out_ready <= 1'b1;
				RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
				RX_SPARSE: out_ready <= (mode_left % 4 == 0);
				default:   out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Called at a rising edge. Valid stays high across back-to-back items.
	task automatic send_item(logic op, logic [7:0] slot, logic [7:0] bid, logic [63:0] word,
			logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		operation <= op;
		palette_slot <= slot;
		palette_block_id <= bid;
		packed_word <= word;
		last_word <= last;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		items_sent++;
		if (op == OP_PALETTE_WRITE) begin
			pal_mem[slot] = bid;
			pal_written[slot] = 1'b1;
		end else begin
			unpack_word(word, last);
		end
	endtask

	task automatic send_entry(logic [7:0] slot, logic [7:0] bid);
		send_item(OP_PALETTE_WRITE, slot, bid, {$urandom, $urandom}, 1'($urandom));
	endtask

	task automatic send_word(logic last);
		send_item(OP_DATA_WORD, 8'($urandom), 8'($urandom), make_packed_word(), last);
	endtask

	// Wait for every queued result, then give a word with no result time to finish.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_cells.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_palette_size(logic [8:0] ps);
		drain_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_PALETTE_SIZE;
		pwdata <= 32'(ps);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		pal_size = ps;
	endtask

	// Entries 0..15 stay written for the whole run, so any 4-bit index is safe.
	task automatic test_palette_load();
		send_entry(8'd0, 8'd0);
		for (int s = 1; s < 15; s++)
			send_entry(8'(s), 8'($urandom));
		send_entry(8'd15, 8'd255);
		send_entry(8'd255, 8'($urandom));
	endtask

	task automatic test_extremes();
		send_item(OP_DATA_WORD, 8'd0, 8'd0, 64'd0, 1'b0);
		// Index 15 is out of range at the reset palette size; the section ends short.
		send_item(OP_DATA_WORD, 8'hff, 8'hff, '1, 1'b1);
		set_palette_size(9'd0);
		send_word(1'b1);
		set_palette_size(9'd1);
		send_word(1'b1);
		set_palette_size(9'h1ff);
		send_word(1'b0);
		send_word(1'b1);
		set_palette_size(9'd256);
		send_word(1'b1);
	endtask

	// At 7 bits the carry grows by one per word; narrowing to 4 bits then leaves
	// a whole index in the carry and more bits than one word can use.
	task automatic test_width_change();
		set_palette_size(9'd100);
		repeat (6) send_word(1'b0);
		set_palette_size(9'd16);
		repeat (2) send_word(1'b0);
		set_palette_size(9'd40);
		send_word(1'b1);
	endtask

	// One full section; it completes in the middle of a word, then extra words
	// and a final last_word give nothing.
	task automatic test_full_section();
		int words;
		set_palette_size(9'd20);
		repeat (3) send_word(1'b0);
		set_palette_size(9'd16);
		words = 0;
		while (cells_done < CELLS_PER_SECTION && cells_done != 0 || words == 0) begin
			if (words == 20 || words == 150)
				hold_req = 1'b1;
			send_word(1'b0);
			words++;
		end
		send_word(1'b0);
		send_word(1'b0);
		send_word(1'b1);
	endtask

	task automatic test_random_sections();
		int size_pick[16] = '{2, 3, 16, 17, 32, 33, 64, 65, 128, 129, 200, 255, 256, 0, 1,
			300};
		int start;
		int nwords;
		logic [8:0] ps;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 1) == 0)
				ps = 9'(size_pick[$urandom_range(0, 15)]);
			else
				ps = 9'($urandom_range(2, 256));
			set_palette_size(ps);
			nwords = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
			for (int k = 0; k < nwords; k++) begin
				if ($urandom_range(0, 4) == 0)
					send_entry(8'($urandom), 8'($urandom));
				send_word(k == nwords - 1);
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_palette_load();
		test_extremes();
		test_width_change();
		test_full_section();
		test_random_sections();
		drain_results();
		if (mismatches == 0 && pending_cells.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
